// ----- hdl/open_addressing_hash_table_defines.svh -----
// Assertion macros shared by the hash table RTL.
// Depends on nothing; users must have signals named clock and reset in scope.
// Include guard follows.
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define OAHT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define OAHT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/oaht_pkg.sv -----
// Package for the open-addressed hash table: sizes, codes, payload types.
// Used by oaht_hash and open_addressing_hash_table; depends on nothing.
package oaht_pkg;

   localparam int TABLE_SLOTS = 16;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int KEY_W       = 16;
   localparam int RSP_SLOT_W  = 4;
   localparam int RSP_COUNT_W = 5;
   localparam int STEP_DIV    = TABLE_SLOTS - 1;

   // Ceiling reciprocals scaled by 2**32; exact quotients for 16-bit keys.
   localparam logic [32:0] HOME_RECIP =
      33'(((64'd1 << 32) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
   localparam logic [32:0] STEP_RECIP =
      33'(((64'd1 << 32) + 64'(STEP_DIV) - 64'd1) / 64'(STEP_DIV));

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic [1:0] MODE_LINEAR    = 2'd0;
   localparam logic [1:0] MODE_QUADRATIC = 2'd1;
   localparam logic [1:0] MODE_DOUBLE    = 2'd2;
   localparam logic [1:0] MODE_UNUSED    = 2'd3;

   localparam logic [1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_FOUND     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef enum logic [1:0] {
      S_IDLE,
      S_HASH,
      S_PREP,
      S_PROBE
   } state_type;

   typedef struct packed {
      logic             cmd;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [RSP_SLOT_W-1:0]  slot;
      logic [RSP_COUNT_W-1:0] probe_count;
   } rsp_type;

   typedef struct packed {
      logic [SLOT_W-1:0] home;
      logic [SLOT_W-1:0] step;
   } hash_type;

endpackage

// ----- hdl/oaht_hash.sv -----
// Home slot and double-hashing step of a key, by reciprocal multiplication.
// Depends on oaht_pkg.
module oaht_hash
   import oaht_pkg::*;
(
   input  logic             clock,
   input  logic             load,
   input  logic [KEY_W-1:0] key,
   output hash_type         hash
);

   logic [48:0]      home_prod;
   logic [48:0]      step_prod;
   logic [KEY_W-1:0] q_home_ff;
   logic [KEY_W-1:0] q_step_ff;
   logic [31:0]      home_rem;
   logic [31:0]      step_rem;
   logic [31:0]      home_fix;
   logic [31:0]      step_fix;

   assign home_prod = 49'(key) * 49'(HOME_RECIP);
   assign step_prod = 49'(key) * 49'(STEP_RECIP);

   // Quotients are registered before the back-multiplication.
   always_ff @(posedge clock) begin
      if (load) begin
         q_home_ff <= home_prod[47:32];
         q_step_ff <= step_prod[47:32];
      end
   end

   always_comb begin
      home_rem = 32'(key) - 32'(q_home_ff) * 32'(TABLE_SLOTS);
      step_rem = 32'(key) - 32'(q_step_ff) * 32'(STEP_DIV);
      home_fix = (home_rem >= 32'(TABLE_SLOTS)) ? home_rem - 32'(TABLE_SLOTS) : home_rem;
      step_fix = (step_rem >= 32'(STEP_DIV)) ? step_rem - 32'(STEP_DIV) : step_rem;
      hash.home = SLOT_W'(home_fix);
      hash.step = SLOT_W'(step_fix + 32'd1);
   end

endmodule

// ----- hdl/open_addressing_hash_table.sv -----
// Open-addressed hash table of TABLE_SLOTS 16-bit keys, insert and search.
// Depends on oaht_pkg, oaht_hash and open_addressing_hash_table_defines.svh.
//
// Usage: a request transfer on req_* carries a command (insert or search)
// and a key. Exactly one response transfer on rsp_* follows for each request,
// giving status, slot and probe count. csr_we/csr_wdata write the probe rule
// (linear, quadratic, double hashing); write it only while no request is open.
// Sequence: after a request transfer the block registers the quotients of the
// multiplies, forms the home slot and step, and then probes slots one after
// another (1 to TABLE_SLOTS), the key memory delivering one entry per cycle.
// The response is registered when the last probe ends. Requests are processed
// one at a time. Reset clears the slot occupancy bits, the probe rule, the
// sequencer state and the response valid flag at once; there is no clearing
// pass.
// When the receiver stalls, the finished response waits in the output register
// and a new request is still accepted; if the next request finishes while the
// old response is still held, the probe unit stalls on its last slot.
`include "open_addressing_hash_table_defines.svh"

module open_addressing_hash_table
   import oaht_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [1:0]        mode_ff;
   logic              cmd_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [SLOT_W-1:0] cur_pos_ff, cur_pos_in;
   logic [SLOT_W-1:0] inc_ff, inc_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic              bad_ff, bad_in;
   logic [TABLE_SLOTS-1:0] used_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Key storage: one synchronous-read memory, one entry per slot.
   logic [KEY_W-1:0]  key_mem [TABLE_SLOTS];
   logic [KEY_W-1:0]  rd_key_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              mem_we;

   hash_type          hash;
   logic              req_xfer;
   logic              is_search;
   logic              hit_empty;
   logic              hit_match;
   logic              last_probe;
   logic              done;
   logic              out_free;
   logic              finish;
   logic              advance;
   logic [SLOT_W:0]   pos_sum;
   logic [SLOT_W:0]   inc_sum;
   logic [SLOT_W-1:0] next_pos;
   logic [SLOT_W-1:0] next_inc;

   assign req_xfer  = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   oaht_hash u_hash (
      .clock (clock),
      .load  (state_ff == S_HASH),
      .key   (key_ff),
      .hash  (hash)
   );

   // Probe evaluation: rd_key_ff holds the key stored at cur_pos_ff.
   assign is_search  = (cmd_ff == CMD_SEARCH);
   assign hit_empty  = !used_ff[cur_pos_ff];
   assign hit_match  = is_search && !hit_empty && (rd_key_ff == key_ff);
   assign last_probe = (count_ff == SLOT_W'(TABLE_SLOTS - 1));
   assign done       = bad_ff || hit_empty || hit_match || last_probe;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign finish     = (state_ff == S_PROBE) && done && out_free;
   assign advance    = (state_ff == S_PROBE) && !done;
   assign mem_we     = finish && !bad_ff && hit_empty && !is_search;

   // Next probe slot and the quadratic increment, each reduced by one subtract.
   always_comb begin
      pos_sum  = {1'b0, cur_pos_ff} + {1'b0, inc_ff};
      next_pos = (pos_sum >= (SLOT_W+1)'(TABLE_SLOTS)) ?
                 SLOT_W'(pos_sum - (SLOT_W+1)'(TABLE_SLOTS)) : SLOT_W'(pos_sum);
      inc_sum  = {1'b0, inc_ff} + (SLOT_W+1)'(2);
      next_inc = (inc_sum >= (SLOT_W+1)'(TABLE_SLOTS)) ?
                 SLOT_W'(inc_sum - (SLOT_W+1)'(TABLE_SLOTS)) : SLOT_W'(inc_sum);
   end

   // Read address: home slot on entry, next slot while probing, else hold.
   always_comb begin
      if (state_ff == S_PREP) begin
         rd_addr = hash.home;
      end else if (advance) begin
         rd_addr = next_pos;
      end else begin
         rd_addr = cur_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[cur_pos_ff] <= key_ff;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   // Response contents for the probe that ends the request.
   always_comb begin
      rsp_data_in.slot        = RSP_SLOT_W'(cur_pos_ff);
      rsp_data_in.probe_count = RSP_COUNT_W'(count_ff);
      if (bad_ff) begin
         rsp_data_in.status = is_search ? STATUS_NOT_FOUND : STATUS_FULL;
      end else if (hit_empty) begin
         rsp_data_in.status = is_search ? STATUS_NOT_FOUND : STATUS_INSERTED;
      end else if (hit_match) begin
         rsp_data_in.status = STATUS_FOUND;
      end else begin
         rsp_data_in.status      = is_search ? STATUS_NOT_FOUND : STATUS_FULL;
         rsp_data_in.probe_count = RSP_COUNT_W'(TABLE_SLOTS);
      end
   end

   // Control sequencer.
   always_comb begin
      state_in   = state_ff;
      cur_pos_in = cur_pos_ff;
      inc_in     = inc_ff;
      count_in   = count_ff;
      bad_in     = bad_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            state_in = S_PREP;
         end
         S_PREP: begin
            state_in   = S_PROBE;
            cur_pos_in = hash.home;
            count_in   = '0;
            bad_in     = (mode_ff == MODE_UNUSED);
            inc_in     = (mode_ff == MODE_DOUBLE) ? hash.step : SLOT_W'(1);
         end
         S_PROBE: begin
            if (finish) begin
               state_in = S_IDLE;
            end else if (advance) begin
               cur_pos_in = next_pos;
               count_in   = count_ff + SLOT_W'(1);
               if (mode_ff == MODE_QUADRATIC) begin
                  inc_in = next_inc;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_pos_ff <= cur_pos_in;
      inc_ff     <= inc_in;
      count_ff   <= count_in;
      bad_ff     <= bad_in;
      if (req_xfer) begin
         cmd_ff <= req_data.cmd;
         key_ff <= req_data.key;
      end
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_LINEAR;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         if (mem_we) begin
            used_ff[cur_pos_ff] <= 1'b1;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // An insert only ever lands in a slot that was free.
   `OAHT_ASSERT_IMP(a_insert_free_slot, mem_we, !used_ff[cur_pos_ff], "insert hit a used slot")
   // The occupancy bit follows the key write.
   `OAHT_ASSERT_NXT(a_used_after_write, mem_we, used_ff[$past(cur_pos_ff)], "used bit not set")
   // Probing always starts at probe zero on the home slot.
   `OAHT_ASSERT_NXT(a_probe_start, state_ff == S_PREP,
      state_ff == S_PROBE && count_ff == '0, "probe did not restart at zero")

endmodule
